/* rtl/szc_pkg.sv */
package szc_pkg;

   localparam int GRAN_W   = 16;
   localparam int ADDR_W   = 20;
   localparam int SIZE_W   = 16;
   localparam int CLASS_W  = 3;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 17;
   localparam int WIDE_CLASS_W = 4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_POOL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [GRAN_W-1:0] granule;
   } szc_link_type;

   typedef struct packed {
      logic              we;
      logic [GRAN_W-1:0] waddr;
      szc_link_type      wdata;
      logic              re;
      logic [GRAN_W-1:0] raddr;
   } szc_ram_req_type;

endpackage

/* rtl/szc_link_ram.sv */
module szc_link_ram
   import szc_pkg::*;
(
   input  logic            clock,
   input  szc_ram_req_type ram_req,
   output szc_link_type    rd_data
);

   localparam int DEPTH = 1 << GRAN_W;

   szc_link_type mem [DEPTH];
   szc_link_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/szc_class_decode.sv */
module szc_class_decode
   import szc_pkg::*;
#(
   parameter int NUM_CLASSES = 8
) (
   input  logic [SIZE_W-1:0]                             size,
   output logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] cls,
   output logic                                          too_large
);

   localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam logic [SIZE_W:0] MAX_SIZE = (SIZE_W+1)'(16 << (NUM_CLASSES - 1));
   localparam logic [WIDE_CLASS_W-1:0] TOP_CLASS = WIDE_CLASS_W'(NUM_CLASSES - 1);
   localparam int GCNT_W = SIZE_W - 3;

   logic [SIZE_W:0]       size_round;
   logic [GCNT_W-1:0]     gcnt;
   logic [GCNT_W-1:0]     gcnt_m1;
   logic [WIDE_CLASS_W-1:0] cls_wide;
   logic [WIDE_CLASS_W-1:0] cls_clamp;

   always_comb begin
      size_round = {1'b0, size} + (SIZE_W+1)'(15);
      gcnt       = size_round[SIZE_W:4];
      gcnt_m1    = (gcnt == '0) ? '0 : gcnt - GCNT_W'(1);
      cls_wide   = '0;
      for (int i = 0; i < GCNT_W; i++) begin
         if (gcnt_m1[i]) begin
            cls_wide = WIDE_CLASS_W'(i + 1);
         end
      end
      cls_clamp = (cls_wide > TOP_CLASS) ? TOP_CLASS : cls_wide;
      cls       = cls_clamp[CIDX_W-1:0];
      too_large = ({1'b0, size} > MAX_SIZE);
   end

endmodule

/* rtl/size_class_free_list_allocator.sv */
// Power-of-two size-class allocator. A request allocates (func 0) or frees
// (func 1) a block of 16 << class bytes; the class follows from request_size
// and anything above 16 << (NUM_CLASSES-1) bytes returns status 2. Allocation
// pops the class's LIFO free list, or carves a new block from a bump pointer
// bounded by pool_size_granules, returning status 1 when the pool is spent.
// Free list links live in a 64K-entry link memory with a registered read.
// The idle state decodes the class and starts the link memory read at the
// list head; the exec state, once the response register is free, updates the
// head, the link memory and the bump pointer and loads the response register.
// A new request is taken while an earlier response still waits. The link
// memory needs no clearing after reset. Write the pool size only while idle.
module size_class_free_list_allocator
   import szc_pkg::*;
#(
   parameter int POOL_GRANULES = 65536,
   parameter int NUM_CLASSES   = 8
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [ADDR_W-1:0]   req_block_address,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADDR_W-1:0]   rsp_granted_address,
   output logic [CLASS_W-1:0]  rsp_size_class,
   output logic [STATUS_W-1:0] rsp_status,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_pool_size_granules
);

   localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam logic [CFG_W-1:0] POOL_CAP =
      (POOL_GRANULES > (1 << GRAN_W)) ? CFG_W'(1 << GRAN_W) : CFG_W'(POOL_GRANULES);
   localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(1 << GRAN_W);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type           state_ff, state_in;
   szc_link_type        heads_ff [NUM_CLASSES];
   szc_link_type        heads_in [NUM_CLASSES];
   logic [CFG_W-1:0]    bump_ff, bump_in;
   logic [CFG_W-1:0]    pool_size_ff, pool_size_in;

   logic                func_ff, func_in;
   logic [CIDX_W-1:0]   cls_ff, cls_in;
   logic                too_large_ff, too_large_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [CLASS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [CIDX_W-1:0]   dec_cls;
   logic                dec_too_large;
   szc_ram_req_type     ram_req;
   szc_link_type        link_rd;

   szc_link_type            head;
   logic [CFG_W-1:0]        pool_lim;
   logic [CFG_W-1:0]        need;
   logic                    fits;
   logic [WIDE_CLASS_W-1:0] cls_wide;

   szc_class_decode #(
      .NUM_CLASSES(NUM_CLASSES)
   ) u_class_decode (
      .size      (req_request_size),
      .cls       (dec_cls),
      .too_large (dec_too_large)
   );

   szc_link_ram u_link_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (link_rd)
   );

   always_comb begin
      state_in      = state_ff;
      heads_in      = heads_ff;
      bump_in       = bump_ff;
      pool_size_in  = pool_size_ff;
      func_in       = func_ff;
      cls_in        = cls_ff;
      too_large_in  = too_large_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_status_in = rsp_status_ff;
      ram_req       = '0;

      head     = heads_ff[cls_ff];
      pool_lim = (pool_size_ff < POOL_CAP) ? pool_size_ff : POOL_CAP;
      need     = CFG_W'(1) << cls_ff;
      fits     = (bump_ff <= pool_lim) && ((pool_lim - bump_ff) >= need);
      cls_wide = WIDE_CLASS_W'(cls_ff);

      if (csr_valid) begin
         pool_size_in = csr_pool_size_granules;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               cls_in       = dec_cls;
               too_large_in = dec_too_large;
               addr_in      = req_block_address;
               ram_req.re   = (req_func == FUNC_ALLOC) && !dec_too_large &&
                              heads_ff[dec_cls].valid;
               ram_req.raddr = heads_ff[dec_cls].granule;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
               rsp_class_in  = cls_wide[CLASS_W-1:0];
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = '0;
               if (too_large_ff) begin
                  rsp_class_in  = '0;
                  rsp_status_in = STATUS_TOO_LARGE;
                  rsp_addr_in   = (func_ff == FUNC_FREE) ? addr_ff : '0;
               end else if (func_ff == FUNC_FREE) begin
                  ram_req.we       = 1'b1;
                  ram_req.waddr    = addr_ff[ADDR_W-1:4];
                  ram_req.wdata    = head;
                  heads_in[cls_ff] = '{valid: 1'b1, granule: addr_ff[ADDR_W-1:4]};
                  rsp_addr_in      = addr_ff;
               end else if (head.valid) begin
                  heads_in[cls_ff] = link_rd;
                  rsp_addr_in      = {head.granule, 4'b0000};
               end else if (fits) begin
                  rsp_addr_in = {bump_ff[GRAN_W-1:0], 4'b0000};
                  bump_in     = bump_ff + need;
               end else begin
                  rsp_status_in = STATUS_NO_POOL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bump_ff      <= '0;
         pool_size_ff <= POOL_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i].valid <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         bump_ff      <= bump_in;
         pool_size_ff <= pool_size_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i].valid <= heads_in[i].valid;
         end
      end
      for (int i = 0; i < NUM_CLASSES; i++) begin
         heads_ff[i].granule <= heads_in[i].granule;
      end
      func_ff       <= func_in;
      cls_ff        <= cls_in;
      too_large_ff  <= too_large_in;
      addr_ff       <= addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_size_class      = rsp_class_ff;
   assign rsp_status          = rsp_status_ff;

endmodule
